[sv/lcrf_pkg.sv]
package lcrf_pkg;

    localparam int VALUE_BITS  = 12;
    localparam int MAX_ITEMS   = 1024;
    localparam int TABLE_DEPTH = 1 << VALUE_BITS;
    localparam int IDX_BITS    = $clog2(MAX_ITEMS);
    localparam int CNT_BITS    = IDX_BITS + 1;

    typedef logic [VALUE_BITS-1:0] value_t;
    typedef logic [IDX_BITS-1:0]   index_t;
    typedef logic [CNT_BITS-1:0]   count_t;

    localparam value_t VALUE_MAX = value_t'(TABLE_DEPTH - 1);
    localparam value_t VALUE_MIN = '0;
    localparam count_t ITEM_MAX  = count_t'(MAX_ITEMS);

    typedef struct packed {
        logic   present;
        logic   visited;
        index_t first_index;
    } entry_t;

    typedef struct packed {
        logic   we;
        value_t waddr;
        entry_t wdata;
        value_t raddr;
    } tbl_req_t;

    typedef enum logic [3:0] {
        ST_WIPE,
        ST_IDLE,
        ST_INSERT,
        ST_SEED_ARD,
        ST_SEED_TRD,
        ST_SEED_CHK,
        ST_UP_CHK,
        ST_DOWN_GO,
        ST_DOWN_CHK,
        ST_CMP,
        ST_FINISH,
        ST_CLEAR
    } state_t;

endpackage

[sv/lcrf_table.sv]
module lcrf_table
(
    input  logic              clk,
    input  lcrf_pkg::tbl_req_t req,
    output lcrf_pkg::entry_t  rd_entry,
    output logic              rd_open
);

    lcrf_pkg::entry_t mem [lcrf_pkg::TABLE_DEPTH];
    lcrf_pkg::entry_t rd_q;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rd_q <= mem[req.raddr];
    end

    assign rd_entry = rd_q;
    assign rd_open  = rd_q.present & ~rd_q.visited;

endmodule

[sv/longest_consecutive_run_finder_core.sv]
// channel   | signals                                   | handshake
// ----------+-------------------------------------------+------------------------------
// request   | element_value, last_item                  | taken when start && !busy
// result    | seq_start, seq_end, run_length            | one-cycle done strobe
//
// a stored request reads the table, then inserts the value if it is not yet present; a
// request beyond the item limit is not stored
// on the last item each seed reads the arrival store, then the table, then checks it; an
// unvisited seed probes the table up and down, then turns and compares; done is
// registered in ST_FINISH, and ST_CLEAR then clears the used entries
// after reset the value table is wiped with busy high
// the result receiver cannot stall; done is high for exactly one cycle
module longest_consecutive_run_finder_core
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  lcrf_pkg::value_t         element_value,
    input  logic                     last_item,
    output logic                     done,
    output lcrf_pkg::value_t         seq_start,
    output lcrf_pkg::value_t         seq_end,
    output lcrf_pkg::count_t         run_length
);

    lcrf_pkg::state_t state_reg, state_next;

    lcrf_pkg::count_t count_reg, count_next;
    lcrf_pkg::count_t ptr_reg, ptr_next;
    lcrf_pkg::value_t probe_reg, probe_next;
    lcrf_pkg::value_t seed_reg, seed_next;
    lcrf_pkg::value_t low_reg, low_next;
    lcrf_pkg::index_t low_idx_reg, low_idx_next;
    lcrf_pkg::count_t len_reg, len_next;
    lcrf_pkg::count_t best_len_reg, best_len_next;
    lcrf_pkg::value_t best_start_reg, best_start_next;
    lcrf_pkg::index_t best_idx_reg, best_idx_next;
    logic             last_reg, last_next;
    logic             pend_reg, pend_next;
    logic             done_reg, done_next;
    lcrf_pkg::value_t seq_start_reg, seq_start_next;
    lcrf_pkg::value_t seq_end_reg, seq_end_next;
    lcrf_pkg::count_t run_length_reg, run_length_next;

    lcrf_pkg::tbl_req_t tbl_req;
    lcrf_pkg::entry_t   tbl_rd;
    logic               tbl_open;

    lcrf_pkg::value_t arr_mem [lcrf_pkg::MAX_ITEMS];
    lcrf_pkg::value_t arr_q;
    logic             arr_we;
    lcrf_pkg::index_t arr_waddr;
    lcrf_pkg::index_t arr_raddr;

    logic             accept;
    logic             has_room;
    logic             last_seed;
    lcrf_pkg::count_t ptr_inc;

    lcrf_table u_table
    (
        .clk      (clk),
        .req      (tbl_req),
        .rd_entry (tbl_rd),
        .rd_open  (tbl_open)
    );

    assign busy      = (state_reg != lcrf_pkg::ST_IDLE);
    assign accept    = start & ~busy;
    assign has_room  = (count_reg < lcrf_pkg::ITEM_MAX);
    assign ptr_inc   = lcrf_pkg::count_t'(ptr_reg + 1'b1);
    assign last_seed = (ptr_inc == count_reg);

    // arrival store
    always_ff @(posedge clk)
    begin
        if (arr_we)
        begin
            arr_mem[arr_waddr] <= element_value;
        end
        arr_q <= arr_mem[arr_raddr];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lcrf_pkg::ST_WIPE:
            begin
                if (probe_reg == lcrf_pkg::VALUE_MAX)
                begin
                    state_next = lcrf_pkg::ST_IDLE;
                end
            end
            lcrf_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    if (has_room)
                    begin
                        state_next = lcrf_pkg::ST_INSERT;
                    end
                    else if (last_item)
                    begin
                        state_next = lcrf_pkg::ST_SEED_ARD;
                    end
                end
            end
            lcrf_pkg::ST_INSERT:
            begin
                state_next = last_reg ? lcrf_pkg::ST_SEED_ARD : lcrf_pkg::ST_IDLE;
            end
            lcrf_pkg::ST_SEED_ARD:
            begin
                state_next = lcrf_pkg::ST_SEED_TRD;
            end
            lcrf_pkg::ST_SEED_TRD:
            begin
                state_next = lcrf_pkg::ST_SEED_CHK;
            end
            lcrf_pkg::ST_SEED_CHK:
            begin
                if (!tbl_open)
                begin
                    state_next = last_seed ? lcrf_pkg::ST_FINISH : lcrf_pkg::ST_SEED_ARD;
                end
                else if (seed_reg == lcrf_pkg::VALUE_MAX)
                begin
                    state_next = lcrf_pkg::ST_DOWN_GO;
                end
                else
                begin
                    state_next = lcrf_pkg::ST_UP_CHK;
                end
            end
            lcrf_pkg::ST_UP_CHK:
            begin
                if (!tbl_open || probe_reg == lcrf_pkg::VALUE_MAX)
                begin
                    state_next = lcrf_pkg::ST_DOWN_GO;
                end
            end
            lcrf_pkg::ST_DOWN_GO:
            begin
                state_next = (seed_reg == lcrf_pkg::VALUE_MIN) ?
                             lcrf_pkg::ST_CMP : lcrf_pkg::ST_DOWN_CHK;
            end
            lcrf_pkg::ST_DOWN_CHK:
            begin
                if (!tbl_open || probe_reg == lcrf_pkg::VALUE_MIN)
                begin
                    state_next = lcrf_pkg::ST_CMP;
                end
            end
            lcrf_pkg::ST_CMP:
            begin
                state_next = last_seed ? lcrf_pkg::ST_FINISH : lcrf_pkg::ST_SEED_ARD;
            end
            lcrf_pkg::ST_FINISH:
            begin
                state_next = lcrf_pkg::ST_CLEAR;
            end
            lcrf_pkg::ST_CLEAR:
            begin
                if (ptr_reg == count_reg)
                begin
                    state_next = lcrf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lcrf_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and memory requests
    always_comb
    begin
        count_next      = count_reg;
        ptr_next        = ptr_reg;
        probe_next      = probe_reg;
        seed_next       = seed_reg;
        low_next        = low_reg;
        low_idx_next    = low_idx_reg;
        len_next        = len_reg;
        best_len_next   = best_len_reg;
        best_start_next = best_start_reg;
        best_idx_next   = best_idx_reg;
        last_next       = last_reg;
        pend_next       = pend_reg;
        done_next       = 1'b0;
        seq_start_next  = seq_start_reg;
        seq_end_next    = seq_end_reg;
        run_length_next = run_length_reg;

        arr_we    = 1'b0;
        arr_waddr = count_reg[lcrf_pkg::IDX_BITS-1:0];
        arr_raddr = ptr_reg[lcrf_pkg::IDX_BITS-1:0];

        tbl_req.we    = 1'b0;
        tbl_req.waddr = probe_reg;
        tbl_req.wdata = '0;
        tbl_req.raddr = probe_reg;

        case (state_reg)
            lcrf_pkg::ST_WIPE:
            begin
                tbl_req.we = 1'b1;
                probe_next = lcrf_pkg::value_t'(probe_reg + 1'b1);
            end
            lcrf_pkg::ST_IDLE:
            begin
                tbl_req.raddr = element_value;
                if (accept)
                begin
                    probe_next   = element_value;
                    low_idx_next = count_reg[lcrf_pkg::IDX_BITS-1:0];
                    last_next    = last_item;
                    ptr_next     = '0;
                    if (has_room)
                    begin
                        arr_we     = 1'b1;
                        count_next = lcrf_pkg::count_t'(count_reg + 1'b1);
                    end
                end
            end
            lcrf_pkg::ST_INSERT:
            begin
                tbl_req.we                  = ~tbl_rd.present;
                tbl_req.wdata.present       = 1'b1;
                tbl_req.wdata.first_index   = low_idx_reg;
            end
            lcrf_pkg::ST_SEED_ARD:
            begin
                arr_raddr = ptr_reg[lcrf_pkg::IDX_BITS-1:0];
            end
            lcrf_pkg::ST_SEED_TRD:
            begin
                tbl_req.raddr = arr_q;
                seed_next     = arr_q;
            end
            lcrf_pkg::ST_SEED_CHK:
            begin
                if (tbl_open)
                begin
                    tbl_req.we    = 1'b1;
                    tbl_req.waddr = seed_reg;
                    tbl_req.wdata = tbl_rd;
                    tbl_req.wdata.visited = 1'b1;
                    len_next      = lcrf_pkg::count_t'(1);
                    low_next      = seed_reg;
                    low_idx_next  = tbl_rd.first_index;
                    probe_next    = lcrf_pkg::value_t'(seed_reg + 1'b1);
                    tbl_req.raddr = lcrf_pkg::value_t'(seed_reg + 1'b1);
                end
                else
                begin
                    ptr_next = ptr_inc;
                end
            end
            lcrf_pkg::ST_UP_CHK:
            begin
                if (tbl_open)
                begin
                    tbl_req.we    = 1'b1;
                    tbl_req.wdata = tbl_rd;
                    tbl_req.wdata.visited = 1'b1;
                    len_next      = lcrf_pkg::count_t'(len_reg + 1'b1);
                    probe_next    = lcrf_pkg::value_t'(probe_reg + 1'b1);
                    tbl_req.raddr = lcrf_pkg::value_t'(probe_reg + 1'b1);
                end
            end
            lcrf_pkg::ST_DOWN_GO:
            begin
                probe_next    = lcrf_pkg::value_t'(seed_reg - 1'b1);
                tbl_req.raddr = lcrf_pkg::value_t'(seed_reg - 1'b1);
            end
            lcrf_pkg::ST_DOWN_CHK:
            begin
                if (tbl_open)
                begin
                    tbl_req.we    = 1'b1;
                    tbl_req.wdata = tbl_rd;
                    tbl_req.wdata.visited = 1'b1;
                    len_next      = lcrf_pkg::count_t'(len_reg + 1'b1);
                    low_next      = probe_reg;
                    low_idx_next  = tbl_rd.first_index;
                    probe_next    = lcrf_pkg::value_t'(probe_reg - 1'b1);
                    tbl_req.raddr = lcrf_pkg::value_t'(probe_reg - 1'b1);
                end
            end
            lcrf_pkg::ST_CMP:
            begin
                ptr_next = ptr_inc;
                if (len_reg > best_len_reg ||
                    (len_reg == best_len_reg && low_idx_reg < best_idx_reg))
                begin
                    best_len_next   = len_reg;
                    best_start_next = low_reg;
                    best_idx_next   = low_idx_reg;
                end
            end
            lcrf_pkg::ST_FINISH:
            begin
                done_next       = 1'b1;
                seq_start_next  = best_start_reg;
                seq_end_next    = lcrf_pkg::value_t'(best_start_reg
                                  + lcrf_pkg::value_t'(best_len_reg) - 1'b1);
                run_length_next = best_len_reg;
                best_len_next   = '0;
                best_start_next = '0;
                best_idx_next   = '1;
                ptr_next        = '0;
                pend_next       = 1'b0;
            end
            lcrf_pkg::ST_CLEAR:
            begin
                arr_raddr     = ptr_reg[lcrf_pkg::IDX_BITS-1:0];
                tbl_req.we    = pend_reg;
                tbl_req.waddr = arr_q;
                pend_next     = (ptr_reg != count_reg);
                if (ptr_reg != count_reg)
                begin
                    ptr_next = ptr_inc;
                end
                else
                begin
                    count_next = '0;
                    ptr_next   = '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= lcrf_pkg::ST_WIPE;
            count_reg    <= '0;
            ptr_reg      <= '0;
            probe_reg    <= '0;
            best_len_reg <= '0;
            best_start_reg <= '0;
            best_idx_reg <= '1;
            last_reg     <= 1'b0;
            pend_reg     <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            ptr_reg      <= ptr_next;
            probe_reg    <= probe_next;
            best_len_reg <= best_len_next;
            best_start_reg <= best_start_next;
            best_idx_reg <= best_idx_next;
            last_reg     <= last_next;
            pend_reg     <= pend_next;
            done_reg     <= done_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        seed_reg       <= seed_next;
        low_reg        <= low_next;
        low_idx_reg    <= low_idx_next;
        len_reg        <= len_next;
        seq_start_reg  <= seq_start_next;
        seq_end_reg    <= seq_end_next;
        run_length_reg <= run_length_next;
    end

    assign done       = done_reg;
    assign seq_start  = seq_start_reg;
    assign seq_end    = seq_end_reg;
    assign run_length = run_length_reg;

`ifndef SYNTHESIS
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> run_length != '0)
        else $error("result with zero run length");

    a_end_order: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> seq_end >= seq_start)
        else $error("run end below run start");

    a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= lcrf_pkg::ITEM_MAX)
        else $error("item count beyond limit");

    a_insert_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && has_room) |=> busy)
        else $error("stored request did not raise busy");
`endif

endmodule
